>>> rtl/hlcp_pkg.sv
// Shared types and constants for the hop-limited cheapest path block.
package hlcp_pkg;

	localparam int NODE_W      = 6;   // node id and stop limit fields
	localparam int COUNT_W     = 7;   // node_count register
	localparam int WEIGHT_IN_W = 16;  // edge_weight field
	localparam int COST_OUT_W  = 22;  // path_cost field

	localparam logic [COUNT_W-1:0]    NODE_COUNT_RESET = 7'd64;
	localparam logic [COST_OUT_W-1:0] PATH_COST_MAX    = 22'h3F_FFFF;

	// item kinds
	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_ADD   = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_COPY,
		ST_EDGE_START,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_ROUND_END,
		ST_FINAL_RD,
		ST_RESULT
	} hlcp_state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_tbl;
		logic add_edge;
		logic load_query;
		logic check_query;
		logic init_query;
		logic node_clr;
		logic copy_step;
		logic edge_first;
		logic edge_fetch;
		logic edge_relax;
		logic round_end;
		logic final_rd;
		logic out_load;
	} hlcp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_range;
		logic node_last;
		logic edge_empty;
		logic edge_last;
		logic round_last;
		logic out_free;
	} hlcp_stat_t;

endpackage

>>> rtl/hlcp_ctrl.sv
// Sequencer for edge loads and the round-by-round relaxation of a query.
module hlcp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            kind,
	output logic                  in_ready,
	output hlcp_pkg::hlcp_cmd_t   cmd,
	input  hlcp_pkg::hlcp_stat_t  stat
);
	import hlcp_pkg::*;

	hlcp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && kind == KIND_QUERY) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = stat.in_range ? ST_COPY : ST_RESULT;
			end
			ST_COPY: begin
				if (stat.node_last) state_d = ST_EDGE_START;
			end
			ST_EDGE_START: begin
				state_d = stat.edge_empty ? ST_ROUND_END : ST_EDGE_A;
			end
			ST_EDGE_A: begin
				state_d = ST_EDGE_B;
			end
			ST_EDGE_B: begin
				state_d = stat.edge_last ? ST_ROUND_END : ST_EDGE_A;
			end
			ST_ROUND_END: begin
				state_d = stat.round_last ? ST_FINAL_RD : ST_COPY;
			end
			ST_FINAL_RD: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (kind)
						KIND_CLEAR: cmd.clear_tbl  = 1'b1;
						KIND_ADD:   cmd.add_edge   = 1'b1;
						KIND_QUERY: cmd.load_query = 1'b1;
						default:    ;
					endcase
				end
			end
			ST_CHECK: begin
				cmd.check_query = 1'b1;
				cmd.init_query  = stat.in_range;
				cmd.node_clr    = stat.in_range;
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
			end
			ST_EDGE_START: begin
				cmd.edge_first = 1'b1;
			end
			ST_EDGE_A: begin
				cmd.edge_fetch = 1'b1;
			end
			ST_EDGE_B: begin
				cmd.edge_relax = 1'b1;
			end
			ST_ROUND_END: begin
				cmd.round_end = 1'b1;
				cmd.node_clr  = 1'b1;
			end
			ST_FINAL_RD: begin
				cmd.final_rd = 1'b1;
			end
			ST_RESULT: begin
				cmd.out_load = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/hlcp_dp.sv
// Datapath: edge table, two cost banks with valid bits, counters and result register.
module hlcp_dp #(
	parameter int MAX_NODES   = 64,
	parameter int MAX_EDGES   = 256,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [hlcp_pkg::COUNT_W-1:0]         cfg_wdata,
	input  logic [hlcp_pkg::NODE_W-1:0]          edge_from,
	input  logic [hlcp_pkg::NODE_W-1:0]          edge_to,
	input  logic [hlcp_pkg::WEIGHT_IN_W-1:0]     edge_weight,
	input  logic [hlcp_pkg::NODE_W-1:0]          query_source,
	input  logic [hlcp_pkg::NODE_W-1:0]          query_target,
	input  logic [hlcp_pkg::NODE_W-1:0]          max_stops,
	input  hlcp_pkg::hlcp_cmd_t                  cmd,
	output hlcp_pkg::hlcp_stat_t                 stat,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 reachable,
	output logic [hlcp_pkg::COST_OUT_W-1:0]      path_cost,
	output logic                                 edges_dropped
);
	import hlcp_pkg::*;

	localparam int NIW    = $clog2(MAX_NODES);
	localparam int CNT_W  = ($clog2(MAX_NODES + 1) > COUNT_W) ? $clog2(MAX_NODES + 1) : COUNT_W;
	localparam int AW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ETW    = $clog2(MAX_EDGES + 1);
	localparam int EW     = 2 * NODE_W + WEIGHT_BITS;
	localparam int CW     = WEIGHT_BITS + NODE_W;   // weight width plus NODE_W bits of headroom for the path sum
	localparam int WIDE_W = CW + COST_OUT_W;

	// configuration and edge table bookkeeping
	logic [COUNT_W-1:0] node_count_q;
	logic [ETW-1:0]     edge_total_q;
	logic               overflow_q;

	// query
	logic [NODE_W-1:0]  src_q, dst_q, stops_q, round_q;
	logic               in_range_q;
	logic               sel_q;          // bank holding previous-round costs
	logic [NIW-1:0]     node_q;
	logic [AW-1:0]      e_q;
	logic [1:0][MAX_NODES-1:0] valid_q;

	// relax stage
	logic [NIW-1:0]         to_s1;
	logic [WEIGHT_BITS-1:0] w_s1;
	logic                   skip_s1;
	logic                   copy_wr_s1;
	logic [NIW-1:0]         copy_addr_s1;

	// memories
	logic [EW-1:0] edge_mem [MAX_EDGES];
	logic [EW-1:0] edge_rd_q;
	logic [CW-1:0] bank_rd_q [2];

	// result register
	logic                  out_valid_q, reach_q, dropped_q;
	logic [COST_OUT_W-1:0] cost_q;

	logic [CNT_W-1:0]       active;
	logic [NIW-1:0]         src_idx, dst_idx, from_idx, to_idx;
	logic [NODE_W-1:0]      e_from, e_to;
	logic [WEIGHT_BITS-1:0] e_w;
	logic                   in_range_now, from_ok, to_ok, skip_now;
	logic [CW-1:0]          prev_rd, next_rd, cand;
	logic                   relax_we;
	logic                   edge_we, edge_re;
	logic [AW-1:0]          edge_raddr;
	logic [1:0]             bank_we, bank_re;
	logic [NIW-1:0]         bank_waddr [2];
	logic [NIW-1:0]         bank_raddr [2];
	logic [CW-1:0]          bank_wdata [2];
	logic                   reach_now;
	logic [CW-1:0]          cost_sel;
	logic [WIDE_W-1:0]      cost_wide;
	logic [COST_OUT_W-1:0]  cost_out;

	// ---- combinational ----
	assign active = (CNT_W'(node_count_q) > CNT_W'(MAX_NODES)) ?
		CNT_W'(MAX_NODES) : CNT_W'(node_count_q);

	assign src_idx      = NIW'(src_q);
	assign dst_idx      = NIW'(dst_q);
	assign in_range_now = (CNT_W'(src_q) < active) && (CNT_W'(dst_q) < active);

	assign e_from   = edge_rd_q[EW-1 -: NODE_W];
	assign e_to     = edge_rd_q[EW-NODE_W-1 -: NODE_W];
	assign e_w      = edge_rd_q[WEIGHT_BITS-1:0];
	assign from_idx = NIW'(e_from);
	assign to_idx   = NIW'(e_to);
	assign from_ok  = CNT_W'(e_from) < active;
	assign to_ok    = CNT_W'(e_to) < active;
	assign skip_now = !from_ok || !to_ok || !valid_q[sel_q][from_idx];

	assign prev_rd  = bank_rd_q[sel_q];
	assign next_rd  = bank_rd_q[~sel_q];
	assign cand     = prev_rd + CW'(w_s1);
	assign relax_we = cmd.edge_relax && !skip_s1 &&
		(!valid_q[~sel_q][to_s1] || cand < next_rd);

	assign edge_we    = cmd.add_edge && (edge_total_q < ETW'(MAX_EDGES));
	assign edge_re    = cmd.edge_first || cmd.edge_relax;
	assign edge_raddr = cmd.edge_first ? '0 : e_q + 1'b1;

	// bank ports follow the bank's role in the current round
	always_comb begin
		for (int b = 0; b < 2; b++) begin
			if (sel_q == 1'(b)) begin
				bank_re[b]    = cmd.copy_step || cmd.edge_fetch || cmd.final_rd;
				bank_raddr[b] = cmd.edge_fetch ? from_idx : (cmd.final_rd ? dst_idx : node_q);
				bank_we[b]    = cmd.init_query;
				bank_waddr[b] = src_idx;
				bank_wdata[b] = '0;
			end else begin
				bank_re[b]    = cmd.edge_fetch;
				bank_raddr[b] = to_idx;
				bank_we[b]    = copy_wr_s1 || relax_we;
				bank_waddr[b] = copy_wr_s1 ? copy_addr_s1 : to_s1;
				bank_wdata[b] = copy_wr_s1 ? prev_rd : cand;
			end
		end
	end

	assign reach_now = in_range_q && valid_q[sel_q][dst_idx];
	assign cost_sel  = reach_now ? prev_rd : '0;
	assign cost_wide = WIDE_W'(cost_sel);
	assign cost_out  = (cost_wide > WIDE_W'(PATH_COST_MAX)) ?
		PATH_COST_MAX : cost_wide[COST_OUT_W-1:0];

	assign stat.in_range   = in_range_now;
	assign stat.node_last  = (CNT_W'(node_q) + 1'b1) == active;
	assign stat.edge_empty = edge_total_q == '0;
	assign stat.edge_last  = (ETW'(e_q) + 1'b1) == edge_total_q;
	assign stat.round_last = round_q == stops_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign reachable     = reach_q;
	assign path_cost     = cost_q;
	assign edges_dropped = dropped_q;

	// ---- memories ----
	always_ff @(posedge clk) begin
		if (edge_we) edge_mem[edge_total_q[AW-1:0]] <= {edge_from, edge_to, WEIGHT_BITS'(edge_weight)};
		if (edge_re) edge_rd_q <= edge_mem[edge_raddr];
	end

	for (genvar gb = 0; gb < 2; gb++) begin : g_bank
		logic [CW-1:0] mem [MAX_NODES];
		always_ff @(posedge clk) begin
			if (bank_we[gb]) mem[bank_waddr[gb]] <= bank_wdata[gb];
			if (bank_re[gb]) bank_rd_q[gb] <= mem[bank_raddr[gb]];
		end
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
			edge_total_q <= '0;
			overflow_q   <= 1'b0;
			in_range_q   <= 1'b0;
			sel_q        <= 1'b0;
			round_q      <= '0;
			node_q       <= '0;
			e_q          <= '0;
			valid_q      <= '0;
			copy_wr_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) node_count_q <= cfg_wdata;

			if (cmd.clear_tbl) begin
				edge_total_q <= '0;
				overflow_q   <= 1'b0;
			end else if (cmd.add_edge) begin
				if (edge_we) edge_total_q <= edge_total_q + 1'b1;
				else         overflow_q   <= 1'b1;
			end

			if (cmd.check_query) in_range_q <= in_range_now;

			// only the source is known at the start of a query
			if (cmd.init_query) begin
				round_q        <= '0;
				valid_q[sel_q] <= MAX_NODES'(1) << src_idx;
			end

			if (cmd.node_clr)       node_q <= '0;
			else if (cmd.copy_step) node_q <= node_q + 1'b1;
			copy_wr_s1 <= cmd.copy_step;

			if (cmd.edge_first) begin
				e_q             <= '0;
				valid_q[~sel_q] <= valid_q[sel_q];
			end
			if (cmd.edge_relax) e_q <= e_q + 1'b1;
			if (relax_we) valid_q[~sel_q][to_s1] <= 1'b1;

			if (cmd.round_end) begin
				sel_q   <= ~sel_q;
				round_q <= round_q + 1'b1;
			end

			if (cmd.out_load)   out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			src_q   <= query_source;
			dst_q   <= query_target;
			stops_q <= max_stops;
		end
		copy_addr_s1 <= node_q;
		if (cmd.edge_fetch) begin
			to_s1   <= to_idx;
			w_s1    <= e_w;
			skip_s1 <= skip_now;
		end
		if (cmd.out_load) begin
			reach_q   <= reach_now;
			cost_q    <= cost_out;
			dropped_q <= overflow_q;
		end
	end

`ifndef ASSERT_OFF
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_total_q <= ETW'(MAX_EDGES))
		else $error("edge count beyond table size");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_tbl |=> (edge_total_q == '0 && !overflow_q))
		else $error("clear did not empty the edge table");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.add_edge && !cmd.clear_tbl && edge_total_q == ETW'(MAX_EDGES)) |=> overflow_q)
		else $error("edge dropped without setting the flag");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	a_bank_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(copy_wr_s1 && cmd.edge_relax))
		else $error("copy write collides with relax write");
`endif

endmodule

>>> rtl/hop_limited_cheapest_path.sv
// Top level: hop-limited cheapest path over a loaded edge table (Bellman-Ford rounds).
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+---------------------
//  in      | kind, edge_from, edge_to, edge_weight,          | in_valid / in_ready
//          | query_source, query_target, max_stops          |
//  out     | reachable, path_cost, edges_dropped            | out_valid / out_ready
//  cfg     | cfg_wdata (node_count)                         | cfg_we, no wait
//
// Clear and add-edge words are handled in the idle state; edges stream in back to back
// while no query is running. A query runs max_stops+1 rounds over the N active nodes
// and E stored edges: each round copies the previous cost bank into the next one (one
// node per cycle), then relaxes every edge (edge table read, then cost read and
// compare-write on the banks). A query with source or target outside the active node
// count skips the rounds and goes straight to its result.
// Reset clears the edge count and drop flag, sets node_count to 64; no clearing pass.
// A finished result waits in the output register; the block takes new words while
// it waits, but a later query holds its own result until the register frees up.
module hop_limited_cheapest_path #(
	parameter int MAX_NODES   = 64,
	parameter int MAX_EDGES   = 256,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [hlcp_pkg::COUNT_W-1:0]       cfg_wdata,
	// input words
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         kind,
	input  logic [hlcp_pkg::NODE_W-1:0]        edge_from,
	input  logic [hlcp_pkg::NODE_W-1:0]        edge_to,
	input  logic [hlcp_pkg::WEIGHT_IN_W-1:0]   edge_weight,
	input  logic [hlcp_pkg::NODE_W-1:0]        query_source,
	input  logic [hlcp_pkg::NODE_W-1:0]        query_target,
	input  logic [hlcp_pkg::NODE_W-1:0]        max_stops,
	// result words
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               reachable,
	output logic [hlcp_pkg::COST_OUT_W-1:0]    path_cost,
	output logic                               edges_dropped
);
	import hlcp_pkg::*;

	hlcp_cmd_t  cmd;
	hlcp_stat_t stat;

	// sequencer: one state per step of a round
	hlcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// edge table, ping-pong cost banks and result register
	hlcp_dp #(
		.MAX_NODES   (MAX_NODES),
		.MAX_EDGES   (MAX_EDGES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.edge_from     (edge_from),
		.edge_to       (edge_to),
		.edge_weight   (edge_weight),
		.query_source  (query_source),
		.query_target  (query_target),
		.max_stops     (max_stops),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.reachable     (reachable),
		.path_cost     (path_cost),
		.edges_dropped (edges_dropped)
	);

endmodule
